@@ sv/tsts_pkg.sv @@
// Package for the tilt scan/track/relay sequencer: phase and config types,
// item structs, timing constants and the tilt fire vote function.
// No dependencies.
package tsts_pkg;

  localparam int unsigned SampleCount   = 5;
  localparam int unsigned SensorBits    = 5;
  localparam int unsigned FireThreshold = 2;

  localparam logic [31:0] StepPeriodMs    = 32'd150;
  localparam logic [31:0] NoFireReleaseMs = 32'd5000;
  localparam logic [7:0]  HomeAngle       = 8'd90;
  localparam logic [7:0]  PanCentre       = 8'd90;
  localparam logic [7:0]  AngleMax        = 8'd255;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    PhWait   = 2'd0,
    PhScan   = 2'd1,
    PhTrack  = 2'd2,
    PhReturn = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScanLow    = 3'd0,
    CfgScanHigh   = 3'd1,
    CfgScanStep   = 3'd2,
    CfgRestAngle  = 3'd3,
    CfgAutoHome   = 3'd4,
    CfgPanDead    = 3'd5,
    CfgTiltHold   = 3'd6,
    CfgPanHold    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  scan_low_angle;
    logic [7:0]  scan_high_angle;
    logic [7:0]  scan_step_deg;
    logic [7:0]  rest_angle;
    logic [15:0] auto_home_ms;
    logic [6:0]  pan_deadzone_deg;
    logic [15:0] tilt_hold_ms;
    logic [15:0] pan_hold_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    scan_low_angle:   8'd0,
    scan_high_angle:  8'd180,
    scan_step_deg:    8'd5,
    rest_angle:       8'd30,
    auto_home_ms:     16'd5000,
    pan_deadzone_deg: 7'd5,
    tilt_hold_ms:     16'd2000,
    pan_hold_ms:      16'd1000
  };

  typedef struct packed {
    logic                  cmd;
    logic [31:0]           now_ms;
    logic                  pan_fire;
    logic                  pan_stable;
    logic [31:0]           pan_stable_since_ms;
    logic [31:0]           last_pan_fire_ms;
    logic [7:0]            pan_angle_deg;
    logic [SensorBits-1:0] sensor_low_bits;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       servo_write;
    logic [7:0] servo_angle;
    logic       relay_on;
    logic       pan_home_pulse;
    logic       pan_unlock_pulse;
    logic [7:0] held_tilt_angle;
  } result_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  scan_pos;
    logic [31:0] step_time;
    logic [31:0] fire_start_time;
    logic [31:0] fire_seen_time;
    logic        relay_state;
    logic [7:0]  tilt_hold;
  } state_t;

  localparam state_t StateReset = '{
    phase:           PhWait,
    scan_pos:        8'd0,
    step_time:       32'd0,
    fire_start_time: 32'd0,
    fire_seen_time:  32'd0,
    relay_state:     1'b0,
    tilt_hold:       8'd30
  };

  // At least FireThreshold of the low SampleCount samples read low.
  function automatic logic tilt_fire(input logic [SensorBits-1:0] bits);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < SensorBits; i++) begin
      if (i < SampleCount && bits[i]) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt >= 4'(FireThreshold);
  endfunction

endpackage

@@ sv/tsts_if.sv @@
// Valid/ready channel interfaces for the sequencer's item and result streams.
// Depends on tsts_pkg for field widths.
interface tsts_item_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [31:0]                     now_ms;
  logic                            pan_fire;
  logic                            pan_stable;
  logic [31:0]                     pan_stable_since_ms;
  logic [31:0]                     last_pan_fire_ms;
  logic [7:0]                      pan_angle_deg;
  logic [tsts_pkg::SensorBits-1:0] sensor_low_bits;

  modport source (
    output valid, cmd, now_ms, pan_fire, pan_stable, pan_stable_since_ms,
           last_pan_fire_ms, pan_angle_deg, sensor_low_bits,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_ms, pan_fire, pan_stable, pan_stable_since_ms,
           last_pan_fire_ms, pan_angle_deg, sensor_low_bits,
    output ready
  );
endinterface

interface tsts_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       servo_write;
  logic [7:0] servo_angle;
  logic       relay_on;
  logic       pan_home_pulse;
  logic       pan_unlock_pulse;
  logic [7:0] held_tilt_angle;

  modport source (
    output valid, mode, servo_write, servo_angle, relay_on, pan_home_pulse,
           pan_unlock_pulse, held_tilt_angle,
    input  ready
  );
  modport sink (
    input  valid, mode, servo_write, servo_angle, relay_on, pan_home_pulse,
           pan_unlock_pulse, held_tilt_angle,
    output ready
  );
endinterface

@@ sv/tsts_cfg_regs.sv @@
// Configuration register bank, written by index, reset to standby defaults.
// Depends on tsts_pkg.
module tsts_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [tsts_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [tsts_pkg::CfgDataW-1:0] data_i,
  output tsts_pkg::cfg_t                cfg_o
);

  tsts_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (tsts_pkg::cfg_idx_e'(idx_i))
        tsts_pkg::CfgScanLow:   cfg_d.scan_low_angle   = data_i[7:0];
        tsts_pkg::CfgScanHigh:  cfg_d.scan_high_angle  = data_i[7:0];
        tsts_pkg::CfgScanStep:  cfg_d.scan_step_deg    = data_i[7:0];
        tsts_pkg::CfgRestAngle: cfg_d.rest_angle       = data_i[7:0];
        tsts_pkg::CfgAutoHome:  cfg_d.auto_home_ms     = data_i;
        tsts_pkg::CfgPanDead:   cfg_d.pan_deadzone_deg = data_i[6:0];
        tsts_pkg::CfgTiltHold:  cfg_d.tilt_hold_ms     = data_i;
        tsts_pkg::CfgPanHold:   cfg_d.pan_hold_ms      = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tsts_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/tsts_step_logic.sv @@
// Next-state and result logic for one item of the four-phase sequencer.
// Purely combinational; depends on tsts_pkg.
module tsts_step_logic (
  input  tsts_pkg::cfg_t    cfg_i,
  input  tsts_pkg::state_t  state_i,
  input  tsts_pkg::item_t   item_i,
  output tsts_pkg::state_t  state_o,
  output tsts_pkg::result_t result_o
);

  logic [31:0] since_fire, since_step, tilt_ms, pan_ms, since_seen;
  logic [7:0]  pan_off;
  logic [8:0]  next_pos;
  logic        step_due, fire, wr, home, unlock, leave;
  logic [7:0]  angle;
  tsts_pkg::state_t s;

  assign since_fire = item_i.now_ms - item_i.last_pan_fire_ms;
  assign since_step = item_i.now_ms - state_i.step_time;
  assign since_seen = item_i.now_ms - state_i.fire_seen_time;
  assign tilt_ms    = item_i.now_ms - state_i.fire_start_time;
  assign pan_ms     = (item_i.pan_stable && item_i.pan_stable_since_ms != 32'd0) ?
                      item_i.now_ms - item_i.pan_stable_since_ms : 32'd0;
  assign pan_off    = (item_i.pan_angle_deg >= tsts_pkg::PanCentre) ?
                      item_i.pan_angle_deg - tsts_pkg::PanCentre :
                      tsts_pkg::PanCentre - item_i.pan_angle_deg;
  assign step_due   = since_step >= tsts_pkg::StepPeriodMs;
  assign fire       = tsts_pkg::tilt_fire(item_i.sensor_low_bits);
  assign next_pos   = {1'b0, state_i.scan_pos} + {1'b0, cfg_i.scan_step_deg};

  always_comb begin
    s      = state_i;
    wr     = 1'b0;
    angle  = '0;
    home   = 1'b0;
    unlock = 1'b0;
    leave  = 1'b0;
    if (item_i.cmd) begin
      s.relay_state     = 1'b0;
      s.phase           = tsts_pkg::PhWait;
      wr                = 1'b1;
      angle             = tsts_pkg::HomeAngle;
      s.tilt_hold       = tsts_pkg::HomeAngle;
      s.fire_start_time = '0;
    end else begin
      case (state_i.phase)
        tsts_pkg::PhWait: begin
          if (item_i.pan_stable) begin
            s.scan_pos  = cfg_i.scan_low_angle;
            s.step_time = item_i.now_ms;
            s.phase     = tsts_pkg::PhScan;
          end else if (since_fire > {16'd0, cfg_i.auto_home_ms}) begin
            home = pan_off > {1'b0, cfg_i.pan_deadzone_deg};
          end
        end
        tsts_pkg::PhScan: begin
          if (!item_i.pan_fire) begin
            s.phase = tsts_pkg::PhReturn;
          end else if (step_due) begin
            s.step_time = item_i.now_ms;
            wr          = 1'b1;
            angle       = state_i.scan_pos;
            if (fire) begin
              s.tilt_hold       = state_i.scan_pos;
              s.fire_start_time = item_i.now_ms;
              s.fire_seen_time  = item_i.now_ms;
              s.relay_state     = 1'b0;
              s.phase           = tsts_pkg::PhTrack;
            end else begin
              if (next_pos > {1'b0, cfg_i.scan_high_angle}) begin
                s.phase = tsts_pkg::PhReturn;
              end
              s.scan_pos = next_pos[8] ? tsts_pkg::AngleMax : next_pos[7:0];
            end
          end
        end
        tsts_pkg::PhTrack: begin
          if (step_due) begin
            s.step_time = item_i.now_ms;
            if (fire) begin
              s.fire_seen_time = item_i.now_ms;
            end else if (state_i.relay_state) begin
              if (since_seen >= tsts_pkg::NoFireReleaseMs) begin
                s.relay_state = 1'b0;
                leave         = 1'b1;
              end
            end else begin
              leave = 1'b1;
            end
            if (leave) begin
              s.phase = tsts_pkg::PhReturn;
            end else if (!state_i.relay_state &&
                         tilt_ms >= {16'd0, cfg_i.tilt_hold_ms} &&
                         pan_ms >= {16'd0, cfg_i.pan_hold_ms}) begin
              s.relay_state = 1'b1;
            end
          end
        end
        tsts_pkg::PhReturn: begin
          s.relay_state     = 1'b0;
          wr                = 1'b1;
          angle             = cfg_i.rest_angle;
          s.tilt_hold       = cfg_i.rest_angle;
          s.fire_start_time = '0;
          unlock            = 1'b1;
          s.phase           = tsts_pkg::PhWait;
        end
        default: ;
      endcase
    end
  end

  assign state_o                   = s;
  assign result_o.mode             = s.phase;
  assign result_o.servo_write      = wr;
  assign result_o.servo_angle      = angle;
  assign result_o.relay_on         = s.relay_state;
  assign result_o.pan_home_pulse   = home;
  assign result_o.pan_unlock_pulse = unlock;
  assign result_o.held_tilt_angle  = s.tilt_hold;

endmodule

@@ sv/tilt_scan_track_relay_sequencer_unit.sv @@
// Tilt scan/track/relay sequencer. One item enters per clock while result_out
// is not stalled: a transfer on item_in lands in an input register; once the
// result register is free, the sequencer state is updated and the result
// register loaded from that item, and the result is offered on result_out.
// Stalls on result_out back up through the input and result registers only.
// Configuration writes take effect at the edge they are written.
// Depends on tsts_pkg, tsts_if, tsts_cfg_regs and tsts_step_logic.
module tilt_scan_track_relay_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsts_pkg::CfgDataW-1:0] cfg_data_i,
  tsts_item_if.sink                     item_in,
  tsts_result_if.source                 result_out
);

  tsts_pkg::cfg_t    cfg;
  tsts_pkg::item_t   item_q, item_d;
  tsts_pkg::state_t  state_q, state_next;
  tsts_pkg::result_t res_q, res_next;
  logic              in_vld_q, in_vld_d, out_vld_q, out_vld_d;
  logic              out_free, stage_go, in_xfer;

  tsts_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  tsts_step_logic u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_next),
    .result_o (res_next)
  );

  assign out_free      = !out_vld_q || result_out.ready;
  assign stage_go      = in_vld_q && out_free;
  assign item_in.ready = !in_vld_q || out_free;
  assign in_xfer       = item_in.valid && item_in.ready;

  always_comb begin
    item_d.cmd                 = item_in.cmd;
    item_d.now_ms              = item_in.now_ms;
    item_d.pan_fire            = item_in.pan_fire;
    item_d.pan_stable          = item_in.pan_stable;
    item_d.pan_stable_since_ms = item_in.pan_stable_since_ms;
    item_d.last_pan_fire_ms    = item_in.last_pan_fire_ms;
    item_d.pan_angle_deg       = item_in.pan_angle_deg;
    item_d.sensor_low_bits     = item_in.sensor_low_bits;
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (stage_go) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (stage_go) begin
      out_vld_d = 1'b1;
    end else if (result_out.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= tsts_pkg::StateReset;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (stage_go) begin
        state_q <= state_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
    if (stage_go) begin
      res_q <= res_next;
    end
  end

  assign result_out.valid            = out_vld_q;
  assign result_out.mode             = res_q.mode;
  assign result_out.servo_write      = res_q.servo_write;
  assign result_out.servo_angle      = res_q.servo_angle;
  assign result_out.relay_on         = res_q.relay_on;
  assign result_out.pan_home_pulse   = res_q.pan_home_pulse;
  assign result_out.pan_unlock_pulse = res_q.pan_unlock_pulse;
  assign result_out.held_tilt_angle  = res_q.held_tilt_angle;

endmodule

@@ dv/tb_top.sv @@
// Testbench for tilt_scan_track_relay_sequencer_unit: a phase-aware stimulus
// generator, an in-line model of the sequencer and an in-order result checker.
// Depends on tsts_pkg, tsts_if and the sequencer RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned ReportCap  = 100;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_we;
  logic [tsts_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [tsts_pkg::CfgDataW-1:0] cfg_data;

  tsts_item_if   item_if();
  tsts_result_if result_if();

  tilt_scan_track_relay_sequencer_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .item_in    (item_if),
    .result_out (result_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sequencer model state and settings
  tsts_pkg::cfg_t   settings = tsts_pkg::CfgReset;
  tsts_pkg::phase_e seq_phase = tsts_pkg::PhWait;
  logic [7:0]  seq_scan_pos = 8'd0;
  logic [31:0] seq_step_ms = '0;
  logic [31:0] seq_fire_start_ms = '0;
  logic [31:0] seq_fire_seen_ms = '0;
  logic        seq_relay = 1'b0;
  logic [7:0]  seq_tilt_hold = 8'd30;

  tsts_pkg::result_t pending_results[$];
  logic [31:0] wall_ms = '0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned failures = 0;
  int unsigned relay_results = 0;
  int unsigned home_pulses = 0;
  int unsigned unlock_pulses = 0;
  int unsigned track_results = 0;
  int unsigned holdoffs = 0;

  function automatic logic tilt_vote(input logic [tsts_pkg::SensorBits-1:0] s);
    return $countones(s) >= tsts_pkg::FireThreshold;
  endfunction

  function automatic tsts_pkg::result_t advance_sequencer(input tsts_pkg::item_t it);
    tsts_pkg::result_t r;
    logic [31:0] gap;
    logic [31:0] tilt_ms;
    logic [31:0] pan_ms;
    logic [8:0]  next_pos;
    logic [7:0]  pan_off;
    logic        leave;
    r = '0;
    if (it.cmd) begin
      seq_relay = 1'b0;
      seq_phase = tsts_pkg::PhWait;
      r.servo_write = 1'b1;
      r.servo_angle = tsts_pkg::HomeAngle;
      seq_tilt_hold = tsts_pkg::HomeAngle;
      seq_fire_start_ms = '0;
    end else begin
      case (seq_phase)
        tsts_pkg::PhWait: begin
          gap = it.now_ms - it.last_pan_fire_ms;
          if (it.pan_stable) begin
            seq_scan_pos = settings.scan_low_angle;
            seq_step_ms = it.now_ms;
            seq_phase = tsts_pkg::PhScan;
          end else if (gap > {16'd0, settings.auto_home_ms}) begin
            pan_off = (it.pan_angle_deg >= tsts_pkg::PanCentre) ?
                      it.pan_angle_deg - tsts_pkg::PanCentre :
                      tsts_pkg::PanCentre - it.pan_angle_deg;
            r.pan_home_pulse = pan_off > {1'b0, settings.pan_deadzone_deg};
          end
        end
        tsts_pkg::PhScan: begin
          gap = it.now_ms - seq_step_ms;
          if (!it.pan_fire) begin
            seq_phase = tsts_pkg::PhReturn;
          end else if (gap >= tsts_pkg::StepPeriodMs) begin
            seq_step_ms = it.now_ms;
            r.servo_write = 1'b1;
            r.servo_angle = seq_scan_pos;
            if (tilt_vote(it.sensor_low_bits)) begin
              seq_tilt_hold = seq_scan_pos;
              seq_fire_start_ms = it.now_ms;
              seq_fire_seen_ms = it.now_ms;
              seq_relay = 1'b0;
              seq_phase = tsts_pkg::PhTrack;
            end else begin
              next_pos = {1'b0, seq_scan_pos} + {1'b0, settings.scan_step_deg};
              if (next_pos > {1'b0, settings.scan_high_angle}) begin
                seq_phase = tsts_pkg::PhReturn;
              end
              seq_scan_pos = next_pos[8] ? tsts_pkg::AngleMax : next_pos[7:0];
            end
          end
        end
        tsts_pkg::PhTrack: begin
          gap = it.now_ms - seq_step_ms;
          if (gap >= tsts_pkg::StepPeriodMs) begin
            leave = 1'b0;
            seq_step_ms = it.now_ms;
            if (tilt_vote(it.sensor_low_bits)) begin
              seq_fire_seen_ms = it.now_ms;
            end else if (seq_relay) begin
              gap = it.now_ms - seq_fire_seen_ms;
              if (gap >= tsts_pkg::NoFireReleaseMs) begin
                seq_relay = 1'b0;
                leave = 1'b1;
              end
            end else begin
              leave = 1'b1;
            end
            if (leave) begin
              seq_phase = tsts_pkg::PhReturn;
            end else begin
              tilt_ms = it.now_ms - seq_fire_start_ms;
              pan_ms = (it.pan_stable && it.pan_stable_since_ms != '0) ?
                       it.now_ms - it.pan_stable_since_ms : '0;
              if (!seq_relay && tilt_ms >= {16'd0, settings.tilt_hold_ms} &&
                  pan_ms >= {16'd0, settings.pan_hold_ms}) seq_relay = 1'b1;
            end
          end
        end
        default: begin
          seq_relay = 1'b0;
          r.servo_write = 1'b1;
          r.servo_angle = settings.rest_angle;
          seq_tilt_hold = settings.rest_angle;
          seq_fire_start_ms = '0;
          r.pan_unlock_pulse = 1'b1;
          seq_phase = tsts_pkg::PhWait;
        end
      endcase
    end
    r.mode = seq_phase;
    r.relay_on = seq_relay;
    r.held_tilt_angle = seq_tilt_hold;
    return r;
  endfunction

  function automatic tsts_pkg::item_t make_item(input logic cmd, input logic [31:0] now,
                                                input logic pan_fire, input logic stable,
                                                input logic [31:0] since,
                                                input logic [31:0] last_fire,
                                                input logic [7:0] pan,
                                                input logic [4:0] sensors);
    tsts_pkg::item_t it;
    it.cmd = cmd;
    it.now_ms = now;
    it.pan_fire = pan_fire;
    it.pan_stable = stable;
    it.pan_stable_since_ms = since;
    it.last_pan_fire_ms = last_fire;
    it.pan_angle_deg = pan;
    it.sensor_low_bits = sensors;
    return it;
  endfunction

  function automatic logic [4:0] pick_sensors(input bit want_fire);
    logic [4:0] s;
    do s = 5'($urandom_range(0, 31)); while (tilt_vote(s) != want_fire);
    return s;
  endfunction

  // Well-formed ticks shaped by the model's current phase, plus noise.
  function automatic tsts_pkg::item_t next_random_item();
    tsts_pkg::item_t it;
    int unsigned     roll;
    int unsigned     dt;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      it.cmd = 1'($urandom_range(0, 1));
      it.now_ms = $urandom;
      it.pan_fire = 1'($urandom_range(0, 1));
      it.pan_stable = 1'($urandom_range(0, 1));
      it.pan_stable_since_ms = $urandom;
      it.last_pan_fire_ms = $urandom;
      it.pan_angle_deg = 8'($urandom_range(0, 255));
      it.sensor_low_bits = 5'($urandom_range(0, 31));
      return it;
    end
    if ($urandom_range(0, 99) == 0) wall_ms = $urandom;
    dt = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 149) : $urandom_range(150, 400);
    if (seq_phase == tsts_pkg::PhTrack && $urandom_range(0, 99) < 10) begin
      dt = $urandom_range(4000, 6000);
    end
    if (seq_phase == tsts_pkg::PhWait && $urandom_range(0, 99) < 30) begin
      dt = $urandom_range(0, 9000);
    end
    wall_ms = wall_ms + dt;
    it.cmd = (roll >= 97);
    it.now_ms = wall_ms;
    it.pan_fire = (seq_phase == tsts_pkg::PhWait) ? 1'($urandom_range(0, 1))
                                                  : ($urandom_range(0, 99) < 93);
    it.pan_stable = $urandom_range(0, 99) < ((seq_phase == tsts_pkg::PhWait) ? 50 : 80);
    it.pan_stable_since_ms = ($urandom_range(0, 99) < 15) ? '0
                             : wall_ms - $urandom_range(0, 3000);
    it.last_pan_fire_ms = wall_ms - $urandom_range(0, 9000);
    it.pan_angle_deg = ($urandom_range(0, 99) < 3) ? 8'($urandom_range(181, 255))
                                                   : 8'($urandom_range(0, 180));
    it.sensor_low_bits = pick_sensors($urandom_range(0, 99) <
                                      ((seq_phase == tsts_pkg::PhTrack) ? 75 : 25));
    return it;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= ReportCap) $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  function automatic void check_result();
    tsts_pkg::result_t want;
    if (pending_results.size() == 0) begin
      failures++;
      if (failures <= ReportCap) $error("result transfer with no expectation pending");
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    check_field("mode", 32'(want.mode), 32'(result_if.mode));
    check_field("servo_write", 32'(want.servo_write), 32'(result_if.servo_write));
    check_field("servo_angle", 32'(want.servo_angle), 32'(result_if.servo_angle));
    check_field("relay_on", 32'(want.relay_on), 32'(result_if.relay_on));
    check_field("pan_home_pulse", 32'(want.pan_home_pulse),
                32'(result_if.pan_home_pulse));
    check_field("pan_unlock_pulse", 32'(want.pan_unlock_pulse),
                32'(result_if.pan_unlock_pulse));
    check_field("held_tilt_angle", 32'(want.held_tilt_angle),
                32'(result_if.held_tilt_angle));
    relay_results += want.relay_on;
    home_pulses += want.pan_home_pulse;
    unlock_pulses += want.pan_unlock_pulse;
    track_results += (want.mode == tsts_pkg::PhTrack);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) check_result();
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Result-side back-pressure
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        holdoffs++;
      end else begin
        result_if.ready <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  task automatic send_item(input tsts_pkg::item_t it);
    while (!calm && $urandom_range(0, 99) < 24) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.cmd <= it.cmd;
    item_if.now_ms <= it.now_ms;
    item_if.pan_fire <= it.pan_fire;
    item_if.pan_stable <= it.pan_stable;
    item_if.pan_stable_since_ms <= it.pan_stable_since_ms;
    item_if.last_pan_fire_ms <= it.last_pan_fire_ms;
    item_if.pan_angle_deg <= it.pan_angle_deg;
    item_if.sensor_low_bits <= it.sensor_low_bits;
    do @(posedge clk_i); while (!item_if.ready);
    pending_results.push_back(advance_sequencer(it));
    items_sent++;
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input tsts_pkg::cfg_idx_e idx,
                           input logic [tsts_pkg::CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input tsts_pkg::cfg_t c);
    drain();
    write_reg(tsts_pkg::CfgScanLow, 16'(c.scan_low_angle));
    write_reg(tsts_pkg::CfgScanHigh, 16'(c.scan_high_angle));
    write_reg(tsts_pkg::CfgScanStep, 16'(c.scan_step_deg));
    write_reg(tsts_pkg::CfgRestAngle, 16'(c.rest_angle));
    write_reg(tsts_pkg::CfgAutoHome, c.auto_home_ms);
    write_reg(tsts_pkg::CfgPanDead, 16'(c.pan_deadzone_deg));
    write_reg(tsts_pkg::CfgTiltHold, c.tilt_hold_ms);
    write_reg(tsts_pkg::CfgPanHold, c.pan_hold_ms);
    cfg_we <= 1'b0;
    settings = c;
  endtask

  function automatic tsts_pkg::cfg_t rand_settings();
    tsts_pkg::cfg_t c;
    c.scan_low_angle = 8'($urandom_range(0, 60));
    c.scan_high_angle = 8'($urandom_range(120, 180));
    c.scan_step_deg = 8'($urandom_range(5, 30));
    c.rest_angle = 8'($urandom_range(0, 180));
    c.auto_home_ms = 16'($urandom_range(0, 8000));
    c.pan_deadzone_deg = 7'($urandom_range(0, 90));
    c.tilt_hold_ms = 16'($urandom_range(0, 1500));
    c.pan_hold_ms = 16'($urandom_range(0, 1500));
    return c;
  endfunction

  // Quiet pan, deadzone edges, timestamp wrap, manual home
  task automatic test_wait_phase();
    send_item(make_item(1'b0, 32'd0, 1'b0, 1'b0, '0, '0, 8'd0, 5'd0));
    send_item(make_item(1'b0, 32'd6000, 1'b0, 1'b0, '0, '0, 8'd0, 5'd0));
    send_item(make_item(1'b0, 32'd6000, 1'b0, 1'b0, '0, '0, 8'd95, 5'd0));
    send_item(make_item(1'b0, 32'd6000, 1'b0, 1'b0, '0, '0, 8'd96, 5'd0));
    send_item(make_item(1'b0, 32'd6000, 1'b1, 1'b0, '0, '0, 8'd255, 5'd31));
    send_item(make_item(1'b0, 32'd2000, 1'b0, 1'b0, '0, 32'hFFFF_F000, 8'd0, 5'd0));
    send_item(make_item(1'b1, '1, 1'b1, 1'b1, '1, '1, 8'd255, 5'd31));
  endtask

  // Scan, lock on, relay on, release after 5 s without fire, park
  task automatic test_scan_and_relay();
    tsts_pkg::cfg_t c;
    logic [31:0]    t;
    c = tsts_pkg::CfgReset;
    c.tilt_hold_ms = 16'd300;
    c.pan_hold_ms = 16'd200;
    load_settings(c);
    t = 32'hFFFF_FF00;
    send_item(make_item(1'b0, t, 1'b1, 1'b1, t, t, 8'd90, 5'd0));
    send_item(make_item(1'b0, t + 32'd100, 1'b1, 1'b1, t, t, 8'd90, 5'b00000));
    send_item(make_item(1'b0, t + 32'd150, 1'b1, 1'b1, t, t, 8'd90, 5'b10000));
    send_item(make_item(1'b0, t + 32'd300, 1'b1, 1'b1, t, t, 8'd90, 5'b10001));
    send_item(make_item(1'b0, t + 32'd400, 1'b1, 1'b1, t, t, 8'd90, 5'b00000));
    send_item(make_item(1'b0, t + 32'd450, 1'b1, 1'b1, t, t, 8'd90, 5'b01100));
    send_item(make_item(1'b0, t + 32'd600, 1'b1, 1'b1, t, t, 8'd90, 5'b11111));
    send_item(make_item(1'b0, t + 32'd750, 1'b1, 1'b0, '0, t, 8'd90, 5'b00100));
    send_item(make_item(1'b0, t + 32'd5600, 1'b1, 1'b0, '0, t, 8'd90, 5'b00000));
    send_item(make_item(1'b0, t + 32'd5700, 1'b1, 1'b0, '0, t, 8'd90, 5'b00000));
  endtask

  // Overflow past the top angle, pan fire loss mid scan, never-on return
  task automatic test_scan_edges();
    tsts_pkg::cfg_t c;
    c = tsts_pkg::CfgReset;
    c.scan_low_angle = 8'd180;
    c.scan_high_angle = 8'd180;
    c.scan_step_deg = 8'd180;
    load_settings(c);
    send_item(make_item(1'b0, 32'd1000, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd1150, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd1200, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd2000, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd2010, 1'b0, 1'b1, 32'd1, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd2020, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd3000, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd3150, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'b00011));
    send_item(make_item(1'b0, 32'd3300, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'b01000));
    send_item(make_item(1'b0, 32'd3310, 1'b1, 1'b1, 32'd1, '0, 8'd90, 5'd0));
  endtask

  // Step of zero keeps the servo on one angle
  task automatic test_zero_step();
    tsts_pkg::cfg_t c;
    c = tsts_pkg::CfgReset;
    c.scan_low_angle = 8'd45;
    c.scan_step_deg = 8'd0;
    load_settings(c);
    send_item(make_item(1'b0, 32'd4000, 1'b1, 1'b1, '0, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd4150, 1'b1, 1'b1, '0, '0, 8'd90, 5'd0));
    send_item(make_item(1'b0, 32'd4300, 1'b1, 1'b1, '0, '0, 8'd90, 5'd0));
  endtask

  task automatic test_random_traffic(input tsts_pkg::cfg_t c, input int unsigned count);
    load_settings(c);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 3) hold_req = 1'b1;
      calm = (i >= count / 2) && (i < count / 2 + 80);
      send_item(next_random_item());
    end
    calm = 1'b0;
  endtask

  initial begin
    tsts_pkg::cfg_t c;
    item_if.valid = 1'b0;
    item_if.cmd = 1'b0;
    item_if.now_ms = '0;
    item_if.pan_fire = 1'b0;
    item_if.pan_stable = 1'b0;
    item_if.pan_stable_since_ms = '0;
    item_if.last_pan_fire_ms = '0;
    item_if.pan_angle_deg = '0;
    item_if.sensor_low_bits = '0;
    cfg_we = 1'b0;
    cfg_idx = tsts_pkg::CfgScanLow;
    cfg_data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wait_phase();
    test_scan_and_relay();
    test_scan_edges();
    test_zero_step();

    test_random_traffic(tsts_pkg::CfgReset, 240);
    c = '{scan_low_angle: 8'd0, scan_high_angle: 8'd180, scan_step_deg: 8'd1,
          rest_angle: 8'd0, auto_home_ms: 16'd0, pan_deadzone_deg: 7'd0,
          tilt_hold_ms: 16'd0, pan_hold_ms: 16'd0};
    test_random_traffic(c, 240);
    c = '{scan_low_angle: 8'd180, scan_high_angle: 8'd0, scan_step_deg: 8'd180,
          rest_angle: 8'd180, auto_home_ms: 16'hFFFF, pan_deadzone_deg: 7'd90,
          tilt_hold_ms: 16'hFFFF, pan_hold_ms: 16'hFFFF};
    test_random_traffic(c, 200);
    test_random_traffic(rand_settings(), 260);
    test_random_traffic(rand_settings(), 260);

    drain();
    $display("%0d item transfers, %0d results checked over %0d cycles, %0d receiver hold-offs",
             items_sent, results_checked, cycle_count, holdoffs);
    $display("%0d tracking results, %0d with relay on, %0d pan home and %0d unlock pulses",
             track_results, relay_results, home_pulses, unlock_pulses);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
